FILE: rtl/rdc_pkg.sv
// ----------------------------------------------------------------------------
// rdc_pkg: shared types and constants for the radial distortion map
// Widths of the coordinate, radius, polynomial and divider datapaths.
// ----------------------------------------------------------------------------
package rdc_pkg;

  // Number formats and limits
  localparam int MAX_DIM        = 4096;
  localparam int FRAC_BITS      = 8;
  localparam int COEF_FRAC_BITS = 24;
  localparam int RST_DIM        = 4096;
  localparam int RST_SCALE      = 1000;
  localparam int DEN_BASE       = 1000;

  // Port widths
  localparam int PIX_W   = 12;
  localparam int DIM_W   = 13;
  localparam int COEF_W  = 32;
  localparam int SCALE_W = 16;
  localparam int OUT_W   = 24;
  localparam int IDX_W   = 3;

  // Offsets, squares and radius
  localparam int D_W    = PIX_W + 1;
  localparam int SQ_W   = 2 * PIX_W;
  localparam int D2_W   = SQ_W + 1;
  localparam int ROOT_W = (D2_W + 2 * FRAC_BITS + 1) / 2;
  localparam int RAD_W  = 2 * ROOT_W;

  // Polynomial accumulator, saturated to +-(2^62 - 1)
  localparam int ACC_W    = 63;
  localparam int MAG_W    = ACC_W - 1;
  localparam int HALF_W   = MAG_W / 2;
  localparam int MUL_W    = (MAG_W - HALF_W) + ROOT_W;
  localparam int FULL_W   = MUL_W + HALF_W;
  localparam int SH_W     = FULL_W - FRAC_BITS;
  localparam int HORNER_N = 3;

  // Divider
  localparam int NUM_W  = PIX_W + SCALE_W;
  localparam int SHIFT  = COEF_FRAC_BITS + FRAC_BITS;
  localparam int QB     = 40;
  localparam int DIV_N_W = NUM_W + SHIFT;
  localparam int HI_W   = DIV_N_W - QB;
  localparam int DREM_W = MAG_W + 1;
  localparam int Q_W    = QB + 1;

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_K1     = 3'd2,
    REG_K2     = 3'd3,
    REG_K3     = 3'd4,
    REG_SCALE  = 3'd5
  } cfg_reg_t;

  // Coordinates that travel with the radius and polynomial
  typedef struct packed {
    logic signed [D_W-1:0] dx;
    logic signed [D_W-1:0] dy;
    logic [PIX_W-1:0]      cx;
    logic [PIX_W-1:0]      cy;
  } side_t;

  // Per-axis control that travels with a quotient
  typedef struct packed {
    logic             neg;
    logic             dneg;
    logic [PIX_W-1:0] c;
    logic             dz;
  } div_side_t;

endpackage

FILE: rtl/rdc_sqrt.sv
// ----------------------------------------------------------------------------
// rdc_sqrt: pipelined integer square root
// One root bit per stage, floor of the square root, stalls on en low.
// ----------------------------------------------------------------------------
module rdc_sqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [rdc_pkg::RAD_W-1:0]   in_rad,
  input  rdc_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [rdc_pkg::ROOT_W-1:0]  out_root,
  output rdc_pkg::side_t              out_side
);
  import rdc_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic              vld  [ROOT_W];
  logic [RAD_W-1:0]  rad  [ROOT_W];
  logic [ROOT_W-1:0] root [ROOT_W];
  logic [REM_W-1:0]  rem  [ROOT_W];
  side_t             side [ROOT_W];

  for (genvar i = 0; i < ROOT_W; i++) begin : g_stage
    localparam int P = ROOT_W - 1 - i;
    logic              v_in;
    logic [RAD_W-1:0]  rad_in;
    logic [ROOT_W-1:0] root_in;
    logic [REM_W-1:0]  rem_in;
    side_t             side_in;
    logic [REM_W-1:0]  cur;
    logic [REM_W-1:0]  trial;
    logic              ge;

    if (i == 0) begin : g_first
      assign v_in    = in_vld;
      assign rad_in  = in_rad;
      assign root_in = '0;
      assign rem_in  = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = vld[i-1];
      assign rad_in  = rad[i-1];
      assign root_in = root[i-1];
      assign rem_in  = rem[i-1];
      assign side_in = side[i-1];
    end

    // Bring down the next bit pair and try the next root bit
    always_comb begin
      cur   = {rem_in[REM_W-3:0], rad_in[2*P+1 -: 2]};
      trial = {root_in, 2'b01};
      ge    = cur >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[i]  <= rad_in;
        root[i] <= {root_in[ROOT_W-2:0], ge};
        rem[i]  <= ge ? cur - trial : cur;
        side[i] <= side_in;
      end
    end
  end

  assign out_vld  = vld[ROOT_W-1];
  assign out_root = root[ROOT_W-1];
  assign out_side = side[ROOT_W-1];

endmodule

FILE: rtl/rdc_div.sv
// ----------------------------------------------------------------------------
// rdc_div: pipelined restoring divider with capped quotient
// Quotient of num * 2^SHIFT by dd, one bit per stage, capped at 2^QB.
// ----------------------------------------------------------------------------
module rdc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_vld,
  input  logic [rdc_pkg::NUM_W-1:0]  num,
  input  logic [rdc_pkg::MAG_W-1:0]  dd,
  input  rdc_pkg::div_side_t         in_side,
  output logic                       out_vld,
  output logic [rdc_pkg::Q_W-1:0]    out_q,
  output rdc_pkg::div_side_t         out_side
);
  import rdc_pkg::*;

  logic              vld  [QB+1];
  logic [DREM_W-1:0] rem  [QB+1];
  logic [QB-1:0]     feed [QB+1];
  logic [MAG_W-1:0]  dd_r [QB+1];
  logic              cap  [QB+1];
  logic [QB-1:0]     q    [QB+1];
  div_side_t         side [QB+1];

  logic [DIV_N_W-1:0] nfull;
  logic [HI_W-1:0]    hi;

  // Split the dividend; a top part at or above dd means the cap applies
  always_comb begin
    nfull = {num, {SHIFT{1'b0}}};
    hi    = nfull[DIV_N_W-1:QB];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0]  <= DREM_W'(hi);
      feed[0] <= nfull[QB-1:0];
      dd_r[0] <= dd;
      cap[0]  <= DREM_W'(hi) >= DREM_W'(dd);
      q[0]    <= '0;
      side[0] <= in_side;
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_stage
    logic [DREM_W-1:0] cur;
    logic              ge;

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
      cur = {rem[i-1][DREM_W-2:0], feed[i-1][QB-1]};
      ge  = cur >= DREM_W'(dd_r[i-1]);
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (en) begin
        vld[i] <= vld[i-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= ge ? cur - DREM_W'(dd_r[i-1]) : cur;
        feed[i] <= {feed[i-1][QB-2:0], 1'b0};
        dd_r[i] <= dd_r[i-1];
        cap[i]  <= cap[i-1];
        q[i]    <= {q[i-1][QB-2:0], ge};
        side[i] <= side[i-1];
      end
    end
  end

  assign out_vld  = vld[QB];
  assign out_q    = cap[QB] ? {1'b1, {QB{1'b0}}} : {1'b0, q[QB]};
  assign out_side = side[QB];

endmodule

FILE: rtl/radial_distortion_coord_map.sv
// Throughput: one word per cycle; every stage advances together, and the
// whole pipe holds while a finished result waits on out_ready.
// The depth is set by the 21-stage square root and the 41-stage divider.
// Reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
// radial_distortion_coord_map: radial lens distortion coordinate map
// Maps an output pixel to its source coordinate through a cubic radial model.
// ----------------------------------------------------------------------------
module radial_distortion_coord_map (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rdc_pkg::IDX_W-1:0]          cfg_index,
  input  logic [rdc_pkg::COEF_W-1:0]         cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [rdc_pkg::PIX_W-1:0]          pixel_col,
  input  logic [rdc_pkg::PIX_W-1:0]          pixel_row,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [rdc_pkg::OUT_W-1:0]   src_x,
  output logic signed [rdc_pkg::OUT_W-1:0]   src_y,
  output logic                               den_zero
);
  import rdc_pkg::*;

  localparam int SUM_W = Q_W + 2;
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};
  localparam logic [MAG_W-1:0] LIM = {MAG_W{1'b1}};
  localparam logic signed [ACC_W:0] LIM_P = $signed({2'b00, LIM});
  localparam logic signed [ACC_W:0] LIM_N = -LIM_P;
  localparam logic signed [ACC_W:0] DEN_ONE = (ACC_W+1)'(DEN_BASE) << COEF_FRAC_BITS;

  // Configuration registers
  logic [DIM_W-1:0]         image_width;
  logic [DIM_W-1:0]         image_height;
  logic signed [COEF_W-1:0] coef_linear;
  logic signed [COEF_W-1:0] coef_square;
  logic signed [COEF_W-1:0] coef_cube;
  logic [SCALE_W-1:0]       scale_factor;

  logic adv;

  assign cfg_ready = 1'b1;
  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv;

  // Write a configuration register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(RST_DIM);
      image_height <= DIM_W'(RST_DIM);
      coef_linear  <= '0;
      coef_square  <= '0;
      coef_cube    <= '0;
      scale_factor <= SCALE_W'(RST_SCALE);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_K1:     coef_linear  <= cfg_data;
        REG_K2:     coef_square  <= cfg_data;
        REG_K3:     coef_cube    <= cfg_data;
        REG_SCALE:  scale_factor <= cfg_data[SCALE_W-1:0];
        default:    ;
      endcase
    end
  end

  // Stage 0: centre and offsets
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;
  side_t            side_in;
  logic             s0_v;
  side_t            s0_side;

  always_comb begin
    w_eff      = (image_width > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width;
    h_eff      = (image_height > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height;
    side_in.cx = w_eff[DIM_W-1:1];
    side_in.cy = h_eff[DIM_W-1:1];
    side_in.dx = $signed({1'b0, pixel_col}) - $signed({1'b0, side_in.cx});
    side_in.dy = $signed({1'b0, pixel_row}) - $signed({1'b0, side_in.cy});
  end

  // Stage 1: squares; stage 2: sum of squares
  logic signed [2*D_W-1:0] px;
  logic signed [2*D_W-1:0] py;
  logic                    s1_v;
  logic [SQ_W-1:0]         s1_sqx;
  logic [SQ_W-1:0]         s1_sqy;
  side_t                   s1_side;
  logic                    s2_v;
  logic [D2_W-1:0]         s2_d2;
  side_t                   s2_side;

  assign px = s0_side.dx * s0_side.dx;
  assign py = s0_side.dy * s0_side.dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_v <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s0_v <= in_valid;
      s1_v <= s0_v;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_side <= side_in;
      s1_sqx  <= px[SQ_W-1:0];
      s1_sqy  <= py[SQ_W-1:0];
      s1_side <= s0_side;
      s2_d2   <= {1'b0, s1_sqx} + {1'b0, s1_sqy};
      s2_side <= s1_side;
    end
  end

  // Radius in fixed point
  logic              rt_v;
  logic [ROOT_W-1:0] rt_r;
  side_t             rt_side;

  rdc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (s2_v),
    .in_rad   (RAD_W'({s2_d2, {(2*FRAC_BITS){1'b0}}})),
    .in_side  (s2_side),
    .out_vld  (rt_v),
    .out_root (rt_r),
    .out_side (rt_side)
  );

  // Horner steps: magnitude, partial products, combine and saturate, add
  logic                    hm_v    [HORNER_N];
  logic [MAG_W-1:0]        hm_mag  [HORNER_N];
  logic                    hm_neg  [HORNER_N];
  logic [ROOT_W-1:0]       hm_r    [HORNER_N];
  side_t                   hm_side [HORNER_N];
  logic                    hp_v    [HORNER_N];
  logic [MUL_W-1:0]        hp_lo   [HORNER_N];
  logic [MUL_W-1:0]        hp_hi   [HORNER_N];
  logic                    hp_neg  [HORNER_N];
  logic [ROOT_W-1:0]       hp_r    [HORNER_N];
  side_t                   hp_side [HORNER_N];
  logic                    hq_v    [HORNER_N];
  logic [MAG_W-1:0]        hq_q    [HORNER_N];
  logic                    hq_neg  [HORNER_N];
  logic [ROOT_W-1:0]       hq_r    [HORNER_N];
  side_t                   hq_side [HORNER_N];
  logic                    ha_v    [HORNER_N];
  logic signed [ACC_W-1:0] ha_t    [HORNER_N];
  logic [ROOT_W-1:0]       ha_r    [HORNER_N];
  side_t                   ha_side [HORNER_N];

  for (genvar j = 0; j < HORNER_N; j++) begin : g_horner
    logic                    v_in;
    logic signed [ACC_W-1:0] t_in;
    logic [ROOT_W-1:0]       r_in;
    side_t                   sd_in;
    logic signed [ACC_W:0]   k;
    logic signed [ACC_W-1:0] t_abs;
    logic [FULL_W-1:0]       full;
    logic [SH_W-1:0]         sh;
    logic [MAG_W-1:0]        q;
    logic signed [ACC_W:0]   q_ext;
    logic signed [ACC_W:0]   sum;
    logic signed [ACC_W:0]   sat;

    if (j == 0) begin : g_first
      assign v_in  = rt_v;
      assign t_in  = ACC_W'(coef_cube);
      assign r_in  = rt_r;
      assign sd_in = rt_side;
    end else begin : g_next
      assign v_in  = ha_v[j-1];
      assign t_in  = ha_t[j-1];
      assign r_in  = ha_r[j-1];
      assign sd_in = ha_side[j-1];
    end

    if (j == 0) begin : g_k2
      assign k = (ACC_W+1)'(coef_square);
    end else if (j == 1) begin : g_k1
      assign k = (ACC_W+1)'(coef_linear);
    end else begin : g_k0
      assign k = DEN_ONE;
    end

    // Truncate the product toward zero and saturate, then add the coefficient
    always_comb begin
      t_abs = t_in[ACC_W-1] ? -t_in : t_in;
      full  = {hp_hi[j], {HALF_W{1'b0}}} + FULL_W'(hp_lo[j]);
      sh    = full[FULL_W-1:FRAC_BITS];
      q     = (|sh[SH_W-1:MAG_W]) ? LIM : sh[MAG_W-1:0];
      q_ext = $signed({2'b00, hq_q[j]});
      sum   = hq_neg[j] ? k - q_ext : k + q_ext;
      if (sum > LIM_P) begin
        sat = LIM_P;
      end else if (sum < LIM_N) begin
        sat = LIM_N;
      end else begin
        sat = sum;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        hm_v[j] <= 1'b0;
        hp_v[j] <= 1'b0;
        hq_v[j] <= 1'b0;
        ha_v[j] <= 1'b0;
      end else if (adv) begin
        hm_v[j] <= v_in;
        hp_v[j] <= hm_v[j];
        hq_v[j] <= hp_v[j];
        ha_v[j] <= hq_v[j];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        hm_mag[j]  <= t_abs[MAG_W-1:0];
        hm_neg[j]  <= t_in[ACC_W-1];
        hm_r[j]    <= r_in;
        hm_side[j] <= sd_in;
        hp_lo[j]   <= MUL_W'(hm_mag[j][HALF_W-1:0]) * MUL_W'(hm_r[j]);
        hp_hi[j]   <= MUL_W'(hm_mag[j][MAG_W-1:HALF_W]) * MUL_W'(hm_r[j]);
        hp_neg[j]  <= hm_neg[j];
        hp_r[j]    <= hm_r[j];
        hp_side[j] <= hm_side[j];
        hq_q[j]    <= q;
        hq_neg[j]  <= hp_neg[j];
        hq_r[j]    <= hp_r[j];
        hq_side[j] <= hp_side[j];
        ha_t[j]    <= sat[ACC_W-1:0];
        ha_r[j]    <= hq_r[j];
        ha_side[j] <= hq_side[j];
      end
    end
  end

  // Divider operands: denominator magnitude and scaled offset magnitudes
  logic signed [ACC_W-1:0] den;
  logic signed [ACC_W-1:0] den_abs;
  logic signed [D_W-1:0]   adx;
  logic signed [D_W-1:0]   ady;
  div_side_t               sx_in;
  div_side_t               sy_in;
  logic                    pp_v;
  logic [MAG_W-1:0]        pp_dd;
  logic [NUM_W-1:0]        pp_numx;
  logic [NUM_W-1:0]        pp_numy;
  div_side_t               pp_sx;
  div_side_t               pp_sy;

  always_comb begin
    den        = ha_t[HORNER_N-1];
    den_abs    = den[ACC_W-1] ? -den : den;
    adx        = ha_side[HORNER_N-1].dx[D_W-1] ? -ha_side[HORNER_N-1].dx
                                                : ha_side[HORNER_N-1].dx;
    ady        = ha_side[HORNER_N-1].dy[D_W-1] ? -ha_side[HORNER_N-1].dy
                                                : ha_side[HORNER_N-1].dy;
    sx_in.dneg = ha_side[HORNER_N-1].dx[D_W-1];
    sx_in.neg  = sx_in.dneg ^ den[ACC_W-1];
    sx_in.c    = ha_side[HORNER_N-1].cx;
    sx_in.dz   = den == '0;
    sy_in.dneg = ha_side[HORNER_N-1].dy[D_W-1];
    sy_in.neg  = sy_in.dneg ^ den[ACC_W-1];
    sy_in.c    = ha_side[HORNER_N-1].cy;
    sy_in.dz   = sx_in.dz;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp_v <= 1'b0;
    end else if (adv) begin
      pp_v <= ha_v[HORNER_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp_dd   <= den_abs[MAG_W-1:0];
      pp_numx <= NUM_W'(adx[PIX_W-1:0]) * NUM_W'(scale_factor);
      pp_numy <= NUM_W'(ady[PIX_W-1:0]) * NUM_W'(scale_factor);
      pp_sx   <= sx_in;
      pp_sy   <= sy_in;
    end
  end

  // One divider per axis
  logic             dvx_v;
  logic             dvy_v;
  logic [Q_W-1:0]   qx;
  logic [Q_W-1:0]   qy;
  div_side_t        sdx;
  div_side_t        sdy;

  rdc_div u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (pp_v),
    .num      (pp_numx),
    .dd       (pp_dd),
    .in_side  (pp_sx),
    .out_vld  (dvx_v),
    .out_q    (qx),
    .out_side (sdx)
  );

  rdc_div u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_vld   (pp_v),
    .num      (pp_numy),
    .dd       (pp_dd),
    .in_side  (pp_sy),
    .out_vld  (dvy_v),
    .out_q    (qy),
    .out_side (sdy)
  );

  // Signed offset plus centre, saturated; a zero denominator pins the rail
  function automatic logic signed [OUT_W-1:0] axis_out(input logic [Q_W-1:0] qv,
                                                        input div_side_t s);
    logic signed [SUM_W-1:0] off;
    logic signed [SUM_W-1:0] base;
    logic signed [SUM_W-1:0] total;
    logic signed [OUT_W-1:0] res;
    off   = $signed(SUM_W'(qv));
    off   = s.neg ? -off : off;
    base  = $signed(SUM_W'({s.c, {FRAC_BITS{1'b0}}}));
    total = base + off;
    if (s.dz) begin
      res = s.dneg ? OUT_MIN : OUT_MAX;
    end else if (total > SUM_W'(OUT_MAX)) begin
      res = OUT_MAX;
    end else if (total < SUM_W'(OUT_MIN)) begin
      res = OUT_MIN;
    end else begin
      res = total[OUT_W-1:0];
    end
    return res;
  endfunction

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dvx_v && dvy_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      src_x    <= axis_out(qx, sdx);
      src_y    <= axis_out(qy, sdy);
      den_zero <= sdx.dz;
    end
  end

endmodule

FILE: tb/tb_radial_distortion_coord_map.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radial_distortion_coord_map: self-checking bench for the radial map
// Drives pixel words and register writes with random gaps and stalls, predicts
// each source coordinate in fixed point and checks results in order.
// ----------------------------------------------------------------------------
module tb_radial_distortion_coord_map;
  import rdc_pkg::*;

  localparam int LATENCY = 79;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 1950;
  localparam longint ACC_LIM = 64'sd4611686018427387903;
  localparam longint OUT_MAX = 64'sd8388607;
  localparam longint OUT_MIN = -64'sd8388608;

  // Expected result of one pixel word
  typedef struct {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic                    dz;
  } coord_t;

  // Register copy and coordinate predictor
  class coord_scoreboard;
    int unsigned  width, height, scale;
    longint       k1, k2, k3;
    coord_t       pending[$];
    int           errors;
    int           checked;
    int           zero_dens;

    function void reset_regs();
      width = RST_DIM;
      height = RST_DIM;
      scale = RST_SCALE;
      k1 = 0;
      k2 = 0;
      k3 = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [COEF_W-1:0] v);
      case (idx)
        REG_WIDTH: width = v[DIM_W-1:0];
        REG_HEIGHT: height = v[DIM_W-1:0];
        REG_K1: k1 = longint'($signed(v));
        REG_K2: k2 = longint'($signed(v));
        REG_K3: k3 = longint'($signed(v));
        REG_SCALE: scale = v[SCALE_W-1:0];
        default: ;
      endcase
    endfunction

    // (a * r) >> FRAC_BITS toward zero, saturated
    function longint horner_mul(longint a, longint unsigned r);
      logic [127:0] p;
      logic [127:0] q;
      logic [63:0]  mag;
      mag = (a < 0) ? -a : a;
      p = mag * 128'(r);
      q = p >> FRAC_BITS;
      if (q > 128'(ACC_LIM)) q = 128'(ACC_LIM);
      return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function longint sat_add(longint a, longint b);
      longint s;
      s = a + b;
      if (s > ACC_LIM) s = ACC_LIM;
      if (s < -ACC_LIM) s = -ACC_LIM;
      return s;
    endfunction

    function longint unsigned isqrt(logic [63:0] n);
      logic [63:0] res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function longint axis(longint d, longint c, longint den);
      logic [127:0] num;
      logic [127:0] q;
      logic [63:0]  dm, dd;
      longint       off, s;
      dm = (d < 0) ? -d : d;
      dd = (den < 0) ? -den : den;
      num = (128'(dm) * 128'(scale)) << (COEF_FRAC_BITS + FRAC_BITS);
      q = num / 128'(dd);
      if (q > (128'd1 << 40)) q = 128'd1 << 40;
      off = ((d < 0) != (den < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
      s = c * 256 + off;
      if (s > OUT_MAX) s = OUT_MAX;
      if (s < OUT_MIN) s = OUT_MIN;
      return s;
    endfunction

    function void note_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row);
      longint       w, h, cx, cy, dx, dy, t, den, sx, sy;
      longint unsigned r;
      logic [63:0]  d2;
      coord_t       e;
      w = (width > MAX_DIM) ? MAX_DIM : width;
      h = (height > MAX_DIM) ? MAX_DIM : height;
      cx = w >> 1;
      cy = h >> 1;
      dx = longint'(col) - cx;
      dy = longint'(row) - cy;
      d2 = dx * dx + dy * dy;
      r = isqrt(d2 << (2 * FRAC_BITS));
      t = k3;
      t = sat_add(k2, horner_mul(t, r));
      t = sat_add(k1, horner_mul(t, r));
      den = sat_add(longint'(DEN_BASE) << COEF_FRAC_BITS, horner_mul(t, r));
      if (den == 0) begin
        sx = (dx < 0) ? OUT_MIN : OUT_MAX;
        sy = (dy < 0) ? OUT_MIN : OUT_MAX;
        e.dz = 1'b1;
      end else begin
        sx = axis(dx, cx, den);
        sy = axis(dy, cy, den);
        e.dz = 1'b0;
      end
      e.x = sx[OUT_W-1:0];
      e.y = sy[OUT_W-1:0];
      pending.push_back(e);
    endfunction

    function void check_coord(logic [OUT_W-1:0] x, logic [OUT_W-1:0] y, logic dz);
      coord_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result x=%0d y=%0d dz=%0b", $time,
                 $signed(x), $signed(y), dz);
        errors++;
        return;
      end
      e = pending.pop_front();
      checked++;
      if (dz) zero_dens++;
      if (x !== e.x) begin
        $display("%0t: src_x expected %0d actual %0d", $time, e.x, $signed(x));
        errors++;
      end
      if (y !== e.y) begin
        $display("%0t: src_y expected %0d actual %0d", $time, e.y, $signed(y));
        errors++;
      end
      if (dz !== e.dz) begin
        $display("%0t: den_zero expected %0b actual %0b", $time, e.dz, dz);
        errors++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [COEF_W-1:0] cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [PIX_W-1:0]  pixel_col = '0;
  logic [PIX_W-1:0]  pixel_row = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [OUT_W-1:0] src_x, src_y;
  logic              den_zero;

  coord_scoreboard sb = new();
  int              idle_cycles;
  int              phases_run;
  bit              stall_enable;

  radial_distortion_coord_map dut (.*);

  always #2 clk = ~clk;

  // Watch for a hung pipe
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
        || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Check each accepted result word and redraw the stall
  initial begin
    int gap;
    gap = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        sb.check_coord(src_x, src_y, den_zero);
        gap = stall_enable ? $urandom_range(0, 17) : 0;
        if (gap > 0) out_ready <= 1'b0;
      end else if (!rst) begin
        if (gap > 0) gap--;
        out_ready <= (gap == 0);
      end
    end
  end

  // Hold valid across back-to-back words; drop it only for an idle gap
  task automatic send_pixel(logic [PIX_W-1:0] col, logic [PIX_W-1:0] row, bit gaps);
    int wait_n;
    wait_n = gaps ? $urandom_range(0, 17) : 0;
    if ($urandom_range(0, 3) == 0) wait_n = 0;
    if (wait_n > 0) begin
      in_valid <= 1'b0;
      repeat (wait_n) @(posedge clk);
    end
    in_valid <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(col, row);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [COEF_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, v);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Stop input and wait for the pipe to empty before a register write
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic load_setting(logic [12:0] w, logic [12:0] h, logic [31:0] a,
                              logic [31:0] b, logic [31:0] c, logic [15:0] s);
    drain();
    write_reg(REG_WIDTH, 32'(w));
    write_reg(REG_HEIGHT, 32'(h));
    write_reg(REG_K1, a);
    write_reg(REG_K2, b);
    write_reg(REG_K3, c);
    write_reg(REG_SCALE, 32'(s));
    phases_run++;
  endtask

  // Random pixels, mostly inside the configured image
  task automatic random_pixels(int n);
    logic [PIX_W-1:0] col, row;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0) begin
        col = PIX_W'($urandom);
        row = PIX_W'($urandom);
      end else begin
        col = PIX_W'($urandom_range(0, (sb.width > 1 && sb.width <= MAX_DIM) ?
                                        sb.width - 1 : 4095));
        row = PIX_W'($urandom_range(0, (sb.height > 1 && sb.height <= MAX_DIM) ?
                                        sb.height - 1 : 4095));
      end
      send_pixel(col, row, (i % 200) >= 40);
    end
  endtask

  initial begin
    int per_phase;
    sb.reset_regs();
    stall_enable = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Identity at reset: corners, centre, all-ones and alternating-bit coordinates
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4095, 12'd4095, 0);
    send_pixel(12'd2048, 12'd2048, 0);
    send_pixel(12'd0, 12'd4095, 0);
    send_pixel(12'hAAA, 12'h555, 0);

    // Zero denominator: 1000 + k1*r vanishes at a radius of 8 pixels
    load_setting(13'd16, 13'd16, 32'(-(125 <<< 24)), 32'd0, 32'd0, 16'd1000);
    send_pixel(12'd16, 12'd8, 0);
    send_pixel(12'd0, 12'd8, 0);
    send_pixel(12'd8, 12'd16, 0);
    send_pixel(12'd8, 12'd8, 0);
    // Zero scale, zero dimensions and oversize dimensions
    load_setting(13'd0, 13'd8191, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 16'd0);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4095, 12'd4095, 0);
    load_setting(13'd1, 13'd4097, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'd65535);
    send_pixel(12'd0, 12'd0, 0);
    send_pixel(12'd4095, 12'd1, 0);
    send_pixel(12'd1, 12'd4095, 0);
    // Unknown register indexes are ignored
    drain();
    write_reg(cfg_reg_t'(3'd6), 32'hFFFFFFFF);
    write_reg(cfg_reg_t'(3'd7), 32'h12345678);
    send_pixel(12'd100, 12'd200, 0);

    // Random phases over several settings
    stall_enable = 1'b1;
    per_phase = RANDOM_ITEMS / 8;
    load_setting(13'd4096, 13'd4096, 32'd0, 32'd0, 32'd0, 16'd1000);
    random_pixels(per_phase);
    load_setting(13'd640, 13'd480, 32'(-(1 << 14)), 32'(1 << 4), 32'd0, 16'd1000);
    random_pixels(per_phase);
    load_setting(13'd1920, 13'd1080, 32'(1 << 12), 32'(-(1 << 2)), 32'd1, 16'd1200);
    random_pixels(per_phase);
    load_setting(13'd17, 13'd33, 32'(-1000 <<< 16), 32'd0, 32'd0, 16'd65535);
    random_pixels(per_phase);
    for (int p = 0; p < 4; p++) begin
      load_setting(13'($urandom_range(1, 4096)), 13'($urandom_range(1, 4096)),
                   $urandom, $urandom >> $urandom_range(0, 31),
                   $urandom >> $urandom_range(0, 31), 16'($urandom));
      random_pixels(per_phase);
    end

    // Drain and report
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    $display("Checked %0d coordinate words over %0d register settings, %0d zero denominators.",
             sb.checked, phases_run, sb.zero_dens);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule

FILE: radial_distortion_coord_map.f
rtl/rdc_pkg.sv
rtl/rdc_sqrt.sv
rtl/rdc_div.sv
rtl/radial_distortion_coord_map.sv
tb/tb_radial_distortion_coord_map.sv
